FILE: design/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LSB-first bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int MAX_FIELD_BITS = 64;   // longest field written by one item
  localparam int VALUE_W        = 64;   // width of the value field
  localparam int LEN_W          = 7;    // width of the length field
  localparam int BYTE_W         = 8;
  localparam int FILL_W         = 3;    // bits pending: 0..7
  localparam int WORD_W         = VALUE_W + BYTE_W;  // pending bits plus a field
  localparam int NBYTES_W       = LEN_W - FILL_W + 1; // bytes per item: 0..8
  localparam int IN_TDATA_W     = ((VALUE_W + LEN_W + 7) / 8) * 8;

  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    cmd_t               cmd;
    logic [LEN_W-1:0]   len;    // saturated length
    logic [VALUE_W-1:0] value;  // bits above len cleared
  } item_t;

endpackage

`default_nettype wire

FILE: design/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts input beats, decodes the command, saturates the length and clears
// the value bits above it before the item enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_front (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lbp_pkg::IN_TDATA_W-1:0] in_tdata,  // value, length
  input  wire logic                           in_tuser,  // command
  output logic                                push_valid,
  input  wire logic                           push_ready,
  output lbp_pkg::item_t                      push_item
);

  logic [lbp_pkg::LEN_W-1:0]   len_raw;
  logic [lbp_pkg::LEN_W-1:0]   len_sat;
  logic [lbp_pkg::VALUE_W-1:0] mask;

  assign len_raw = in_tdata[lbp_pkg::VALUE_W +: lbp_pkg::LEN_W];

  always_comb begin
    if (len_raw > lbp_pkg::LEN_W'(lbp_pkg::MAX_FIELD_BITS)) begin
      len_sat = lbp_pkg::LEN_W'(lbp_pkg::MAX_FIELD_BITS);
    end else begin
      len_sat = len_raw;
    end
    if (len_sat >= lbp_pkg::LEN_W'(lbp_pkg::VALUE_W)) begin
      mask = '1;
    end else begin
      mask = (lbp_pkg::VALUE_W'(1) << len_sat) - lbp_pkg::VALUE_W'(1);
    end
  end

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  always_comb begin
    push_item.cmd   = lbp_pkg::cmd_t'(in_tuser);
    push_item.len   = len_sat;
    push_item.value = in_tdata[lbp_pkg::VALUE_W-1:0] & mask;
  end

endmodule

`default_nettype wire

FILE: design/lbp_queue.sv
// ----------------------------------------------------------------------------
// lbp_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire lbp_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output lbp_pkg::item_t      pop_item
);

  lbp_pkg::item_t                entry_r [lbp_pkg::QDEPTH];
  logic [lbp_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lbp_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lbp_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (count_r != lbp_pkg::QCNT_W'(lbp_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == lbp_pkg::QPTR_W'(lbp_pkg::QDEPTH - 1)) ? '0
                   : wr_ptr_r + lbp_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == lbp_pkg::QPTR_W'(lbp_pkg::QDEPTH - 1)) ? '0
                   : rd_ptr_r + lbp_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + lbp_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - lbp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: design/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Merges each item with the pending bits and sends out the completed bytes, one
// per cycle unless out_tready stalls it, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire lbp_pkg::item_t pop_item,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,  // out_byte
  output logic                out_tlast   // last
);

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [lbp_pkg::WORD_W-1:0]      word_r, word_nxt;
  logic [lbp_pkg::NBYTES_W-1:0]    cnt_r, cnt_nxt;
  logic [lbp_pkg::FILL_W-1:0]      rem_r, rem_nxt;
  logic [lbp_pkg::BYTE_W-1:0]      pending_r, pending_nxt;
  logic [lbp_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lbp_pkg::BYTE_W-1:0]      out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            out_free;
  logic [lbp_pkg::LEN_W-1:0]       total;
  logic [lbp_pkg::WORD_W-1:0]      merged;

  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = (state_r == S_IDLE) && out_free;

  // Pending bits sit below the new field; value bits above len are already zero.
  assign total  = lbp_pkg::LEN_W'(fill_r) + pop_item.len;
  assign merged = (lbp_pkg::WORD_W'(pop_item.value) << fill_r)
                | lbp_pkg::WORD_W'(pending_r);

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    pending_nxt   = pending_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (pop_valid && out_free) begin
          if (pop_item.cmd == lbp_pkg::CMD_FLUSH) begin
            if (fill_r != '0) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = pending_r;
              out_last_nxt  = 1'b1;
            end
            pending_nxt = '0;
            fill_nxt    = '0;
          end else if (total[lbp_pkg::LEN_W-1:lbp_pkg::FILL_W] == '0) begin
            pending_nxt = merged[lbp_pkg::BYTE_W-1:0];
            fill_nxt    = total[lbp_pkg::FILL_W-1:0];
          end else begin
            word_nxt  = merged;
            cnt_nxt   = lbp_pkg::NBYTES_W'(total[lbp_pkg::LEN_W-1:lbp_pkg::FILL_W]);
            rem_nxt   = total[lbp_pkg::FILL_W-1:0];
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = word_r[lbp_pkg::BYTE_W-1:0];
          out_last_nxt  = (cnt_r == lbp_pkg::NBYTES_W'(1));
          word_nxt      = word_r >> lbp_pkg::BYTE_W;
          cnt_nxt       = cnt_r - lbp_pkg::NBYTES_W'(1);
          if (cnt_r == lbp_pkg::NBYTES_W'(1)) begin
            // leftover bits become the new pending byte
            pending_nxt = word_r[lbp_pkg::BYTE_W +: lbp_pkg::BYTE_W];
            fill_nxt    = rem_r;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    word_r     <= word_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

FILE: design/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs variable-length bit fields into bytes, least significant bit first.
//
//   channel  direction  tdata                         tuser     tlast
//   in_      slave      [63:0] value, [70:64] length  command   -
//   out_     master     [7:0] out_byte                -         last
//
// A write item is first merged with the pending bits in the back end; then its
// completed bytes go out one per cycle while the output is not stalled. A
// flush sends out a partial pending byte, if any. The back-end sequencer and
// its one-byte output register pace the bytes. A two-entry queue lets the front
// accept items while the back end is still emitting bytes or the output stalls.
// Synchronous active-low reset clears the pending byte and all handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_first_bit_packer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [lbp_pkg::IN_TDATA_W-1:0] in_tdata,  // value, length
  input  wire logic                           in_tuser,  // command
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata, // out_byte
  output logic                                out_tlast  // last
);

  logic           push_valid, push_ready;
  lbp_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  lbp_pkg::item_t pop_item;

  lbp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  lbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  lbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
